// ----- rtl/core/gwcb_pkg.sv -----
// Shared types and constants for the gray-world color balance block.
package gwcb_pkg;

  localparam int FracBits  = 16;
  localparam int MultW     = 8 + FracBits;
  localparam int SumW      = 32;
  localparam int CountW    = 25;
  localparam int DivSteps  = 8 + FracBits + 1;
  localparam logic [CountW-1:0] MaxPixels = 25'd16777216;
  localparam logic [MultW-1:0]  MultOne   = MultW'(1) << FracBits;
  localparam logic [MultW-1:0]  MultMax   = '1;

  localparam logic [6:0]  StrengthReset = 7'd30;
  localparam logic [15:0] TempReset     = 16'd6500;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_CORRECT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_STRENGTH = 2'd0,
    CFG_TEMP     = 2'd1,
    CFG_CAST     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_MUL,
    GS_SUM,
    GS_PRE,
    GS_DIV,
    GS_RND
  } gain_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_empty;
  } out_t;

  typedef struct packed {
    logic       valid;
    cmd_e       cmd;
    logic       opaque;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

  typedef struct packed {
    logic [6:0]  strength;
    logic [15:0] temp;
    logic        cast_en;
  } cfg_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MultW-1:0] mult_red;
    logic [MultW-1:0] mult_green;
    logic [MultW-1:0] mult_blue;
  } gain_res_t;

endpackage

// ----- rtl/core/gwcb_front.sv -----
// Front end: two-entry input queue with command decode.
module gwcb_front import gwcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  input  logic  pop_i,
  output item_t head_o
);

  in_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  always_comb begin
    head_o.valid  = (cnt_q != 2'd0);
    head_o.cmd    = cmd_e'(mem_q[rd_q].cmd);
    head_o.opaque = (mem_q[rd_q].in_alpha != 8'd0);
    head_o.red    = mem_q[rd_q].in_red;
    head_o.green  = mem_q[rd_q].in_green;
    head_o.blue   = mem_q[rd_q].in_blue;
    head_o.alpha  = mem_q[rd_q].in_alpha;
  end

endmodule

// ----- rtl/core/gwcb_gain.sv -----
// Finish sequencer: per-channel multiplier with a bit-serial divider.
module gwcb_gain import gwcb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cfg_t              cfg_i,
  input  logic [SumW-1:0]   sum_red_i,
  input  logic [SumW-1:0]   sum_green_i,
  input  logic [SumW-1:0]   sum_blue_i,
  input  logic [CountW-1:0] count_i,
  output gain_res_t         res_o
);

  gain_state_e state_q, state_d;
  logic [1:0]  ch_q, ch_d;
  logic [4:0]  step_q, step_d;
  logic [33:0] total_q, total_d;
  logic [6:0]  s_q, s_d;
  logic [13:0] tc_q, tc_d;
  logic [63:0] a_q, a_d, n_q, n_d, x_q, x_d, dv_q, dv_d, dsh_q, dsh_d;
  logic [DivSteps-1:0] v_q, v_d;
  logic        sat_q, sat_d;
  logic        done_d;
  logic [MultW-1:0] mr_q, mr_d, mg_q, mg_d, mb_q, mb_d;
  logic [SumW-1:0]  sum_c;
  logic [15:0]      tilt;
  logic             cast;
  logic [63:0]      r2;
  logic [DivSteps:0] vr;
  logic [MultW-1:0]  mval;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_IDLE;
      ch_q    <= 2'd0;
      step_q  <= 5'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    s_q     <= s_d;
    tc_q    <= tc_d;
    a_q     <= a_d;
    n_q     <= n_d;
    x_q     <= x_d;
    dv_q    <= dv_d;
    dsh_q   <= dsh_d;
    v_q     <= v_d;
    sat_q   <= sat_d;
    mr_q    <= mr_d;
    mg_q    <= mg_d;
    mb_q    <= mb_d;
  end

  always_comb begin
    case (ch_q)
      2'd0:    sum_c = sum_red_i;
      2'd1:    sum_c = sum_green_i;
      default: sum_c = sum_blue_i;
    endcase
    case (ch_q)
      2'd0:    tilt = 16'd32500 - {2'b0, tc_q};
      2'd1:    tilt = 16'd26000;
      default: tilt = 16'd19500 + {2'b0, tc_q};
    endcase
    cast = cfg_i.cast_en && ({7'd0, sum_c} > {{SumW-CountW+7{1'b0}}, count_i});
    r2   = {x_q[62:0], 1'b0};
    vr   = {1'b0, v_q} + {{DivSteps{1'b0}}, 1'b1};
    mval = (vr[DivSteps:1] > {1'b0, MultMax}) ? MultMax : vr[MultW:1];
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    step_d  = step_q;
    total_d = total_q;
    s_d     = s_q;
    tc_d    = tc_q;
    a_d     = a_q;
    n_d     = n_q;
    x_d     = x_q;
    dv_d    = dv_q;
    dsh_d   = dsh_q;
    v_d     = v_q;
    sat_d   = sat_q;
    mr_d    = mr_q;
    mg_d    = mg_q;
    mb_d    = mb_q;
    done_d  = 1'b0;
    case (state_q)
      GS_IDLE: begin
        if (start_i) begin
          total_d = {2'b0, sum_red_i} + {2'b0, sum_green_i} + {2'b0, sum_blue_i};
          s_d     = (cfg_i.strength > 7'd100) ? 7'd100 : cfg_i.strength;
          tc_d    = (cfg_i.temp > 16'd13000) ? 14'd13000 : cfg_i.temp[13:0];
          ch_d    = 2'd0;
          state_d = GS_MUL;
        end
      end
      GS_MUL: begin
        // den term 3*sum*26000 and num term total*tilt (26000 and tilt when cast is off)
        a_d = cast ? {32'd0, sum_c} * 64'd78000 : 64'd26000;
        n_d = cast ? {30'd0, total_q} * {48'd0, tilt} : {48'd0, tilt};
        state_d = GS_SUM;
      end
      GS_SUM: begin
        x_d  = {57'd0, 7'd100 - s_q} * a_q + {57'd0, s_q} * n_q;
        dv_d = a_q * 64'd100;
        state_d = GS_PRE;
      end
      GS_PRE: begin
        sat_d  = (x_q >= (dv_q << 8));
        dsh_d  = dv_q << 7;
        v_d    = '0;
        step_d = 5'd0;
        state_d = GS_DIV;
      end
      GS_DIV: begin
        if (step_q < 5'd8) begin
          if (x_q >= dsh_q) begin
            x_d = x_q - dsh_q;
            v_d = {v_q[DivSteps-2:0], 1'b1};
          end else begin
            v_d = {v_q[DivSteps-2:0], 1'b0};
          end
          dsh_d = dsh_q >> 1;
        end else begin
          if (r2 >= dv_q) begin
            x_d = r2 - dv_q;
            v_d = {v_q[DivSteps-2:0], 1'b1};
          end else begin
            x_d = r2;
            v_d = {v_q[DivSteps-2:0], 1'b0};
          end
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'(DivSteps - 1)) state_d = GS_RND;
      end
      GS_RND: begin
        case (ch_q)
          2'd0:    mr_d = sat_q ? MultMax : mval;
          2'd1:    mg_d = sat_q ? MultMax : mval;
          default: mb_d = sat_q ? MultMax : mval;
        endcase
        if (ch_q == 2'd2) begin
          done_d  = 1'b1;
          state_d = GS_IDLE;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = GS_MUL;
        end
      end
      default: state_d = GS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= done_d;
  end

  assign res_o.busy       = (state_q != GS_IDLE) || done_q;
  assign res_o.done       = done_q;
  assign res_o.mult_red   = mr_q;
  assign res_o.mult_green = mg_q;
  assign res_o.mult_blue  = mb_q;

endmodule

// ----- rtl/core/gwcb_back.sv -----
// Back end: statistics, multiplier registers, pixel scaling and output register.
module gwcb_back import gwcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t head_i,
  output logic  pop_o,
  output logic  busy_o,
  input  cfg_t  cfg_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o
);

  logic [SumW-1:0]   sr_q, sg_q, sb_q;
  logic [CountW-1:0] cnt_q;
  logic [MultW-1:0]  mr_q, mg_q, mb_q;
  logic              empty_q;
  logic              ov_q;
  out_t              od_q;
  gain_res_t         gres;
  logic              start;
  logic              can_out;

  gwcb_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cfg_i       (cfg_i),
    .sum_red_i   (sr_q),
    .sum_green_i (sg_q),
    .sum_blue_i  (sb_q),
    .count_i     (cnt_q),
    .res_o       (gres)
  );

  assign busy_o  = gres.busy;
  assign can_out = !ov_q || !out_stall_i;
  assign pop_o   = head_i.valid && !gres.busy &&
                   ((head_i.cmd != CMD_CORRECT) || can_out);
  assign start   = pop_o && (head_i.cmd == CMD_FINISH) && (cnt_q != '0);

  function automatic logic [7:0] scale(input logic [7:0] v, input logic [MultW-1:0] m);
    logic [MultW+7:0] p;
    p = {{8{1'b0}}, m} * {{MultW{1'b0}}, v} + (MultW+8)'(1 << (FracBits - 1));
    if (p[MultW+7:FracBits] > 16'd255) return 8'd255;
    return p[FracBits+7:FracBits];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= '0;
      sg_q    <= '0;
      sb_q    <= '0;
      cnt_q   <= '0;
      mr_q    <= MultOne;
      mg_q    <= MultOne;
      mb_q    <= MultOne;
      empty_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      if (gres.done) begin
        mr_q <= gres.mult_red;
        mg_q <= gres.mult_green;
        mb_q <= gres.mult_blue;
      end
      // a new result replaces one that leaves in the same cycle
      if (pop_o && head_i.cmd == CMD_CORRECT) ov_q <= 1'b1;
      else if (!out_stall_i)                  ov_q <= 1'b0;
      if (pop_o) begin
        case (head_i.cmd)
          CMD_CLEAR: begin
            sr_q  <= '0;
            sg_q  <= '0;
            sb_q  <= '0;
            cnt_q <= '0;
          end
          CMD_MEASURE: begin
            if (head_i.opaque && cnt_q < MaxPixels) begin
              sr_q  <= sr_q + {24'd0, head_i.red};
              sg_q  <= sg_q + {24'd0, head_i.green};
              sb_q  <= sb_q + {24'd0, head_i.blue};
              cnt_q <= cnt_q + CountW'(1);
            end
          end
          CMD_FINISH: begin
            empty_q <= (cnt_q == '0);
            if (cnt_q == '0) begin
              mr_q <= MultOne;
              mg_q <= MultOne;
              mb_q <= MultOne;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.cmd == CMD_CORRECT) begin
      od_q.out_alpha   <= head_i.alpha;
      od_q.frame_empty <= empty_q;
      if (head_i.opaque && !empty_q) begin
        od_q.out_red   <= scale(head_i.red, mr_q);
        od_q.out_green <= scale(head_i.green, mg_q);
        od_q.out_blue  <= scale(head_i.blue, mb_q);
      end else begin
        od_q.out_red   <= head_i.red;
        od_q.out_green <= head_i.green;
        od_q.out_blue  <= head_i.blue;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ----- rtl/core/gray_world_color_balance_top.sv -----
// Top level of the gray-world color balance block.
// Clear, measure and correct each execute in the back end when they are popped;
// a correct result goes from the input queue to the output register. Sustained
// rate is one transaction per cycle for these while no stall or finish holds it.
// A finish with pixels holds the back end through three channel divides and a load.
// Reset (async, active low) clears sums, sets multipliers to 1.0, frame empty.
module gray_world_color_balance_top import gwcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  cfg_t  cfg_q;
  item_t head;
  logic  pop;
  logic  busy;

  // Config registers; writes to the unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strength <= StrengthReset;
      cfg_q.temp     <= TempReset;
      cfg_q.cast_en  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STRENGTH: cfg_q.strength <= cfg_data_i[6:0];
        CFG_TEMP:     cfg_q.temp     <= cfg_data_i;
        CFG_CAST:     cfg_q.cast_en  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: queue and decode; back: executes one transaction at a time.
  gwcb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  gwcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .busy_o      (busy),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid) else $error("pop from empty queue");
  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> head.valid) else $error("full queue without head");
  a_busy_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !pop) else $error("pop while gain unit busy");

endmodule
